>>> rtl/art_pkg.sv
// Shared types and constants of the ack retransmit tracker.
package art_pkg;

  localparam int unsigned CH_W       = 3;
  localparam int unsigned SEQ_W      = 32;
  localparam int unsigned EL_W       = 16;
  localparam int unsigned ACT_W      = 3;
  localparam int unsigned ST_W       = 2;
  localparam int unsigned ACC_W      = 32;
  localparam int unsigned CFG_W      = 16;
  localparam int unsigned CFG_ADDR_W = 1;

  // Stream widths, padded to whole bytes
  localparam int unsigned IN_DATA_W  = 56;
  localparam int unsigned OUT_DATA_W = 40;

  // Configuration register indexes
  localparam logic [CFG_ADDR_W-1:0] REG_SEND_BLOCKED  = 1'b0;
  localparam logic [CFG_ADDR_W-1:0] REG_RETX_INTERVAL = 1'b1;

  localparam logic [CFG_W-1:0] RETX_INTERVAL_RST = 16'd100;

  typedef enum logic [ACT_W-1:0] {
    ACT_REL_SEND   = 3'd0,
    ACT_UNREL_SEND = 3'd1,
    ACT_ACK        = 3'd2,
    ACT_TICK       = 3'd3,
    ACT_QUERY      = 3'd4
  } action_e;

  typedef enum logic [ST_W-1:0] {
    STAT_DONE     = 2'd0,
    STAT_BLOCKED  = 2'd1,
    STAT_FULL     = 2'd2,
    STAT_NOMATCH  = 2'd3
  } status_e;

  // One pending table entry
  typedef struct packed {
    logic [CH_W-1:0]  channel;
    logic [SEQ_W-1:0] seq;
  } entry_t;

  // One result item
  typedef struct packed {
    logic [ST_W-1:0]  status;
    logic [CH_W-1:0]  channel;
    logic [SEQ_W-1:0] seq;
    logic             delivered;
    logic             retransmit;
    logic             last;
  } result_t;

endpackage

>>> rtl/art_pend_mem.sv
// Pending table storage: one write port, one read port, registered read data.
module art_pend_mem #(
  parameter int unsigned ADDR_W = 5,
  parameter int unsigned DATA_W = 35
) (
  input  logic              clk_i,
  input  logic              we_i,
  input  logic [ADDR_W-1:0] waddr_i,
  input  logic [DATA_W-1:0] wdata_i,
  input  logic [ADDR_W-1:0] raddr_i,
  output logic [DATA_W-1:0] rdata_o
);

  logic [DATA_W-1:0] mem_q [1 << ADDR_W];
  logic [DATA_W-1:0] rdata_q;

  // Write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Read port, registered read data
  always_ff @(posedge clk_i) begin
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

>>> rtl/art_out_reg.sv
// Result output register: holds one result until the sink takes it.
module art_out_reg (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                push_i,
  input  art_pkg::result_t                    data_i,
  output logic                                can_load_o,
  output logic                                m_axis_tvalid,
  input  logic                                m_axis_tready,
  // status[1:0], out_channel[4:2], out_seq[36:5], delivered[37], zero pad
  output logic [art_pkg::OUT_DATA_W-1:0]      m_axis_tdata,
  // retransmit[0]
  output logic                                m_axis_tuser,
  output logic                                m_axis_tlast
);

  logic             vld_q;
  art_pkg::result_t res_q;

  assign can_load_o = !vld_q || m_axis_tready;

  // Track occupancy
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else if (push_i) begin
      vld_q <= 1'b1;
    end else if (m_axis_tready) begin
      vld_q <= 1'b0;
    end
  end

  // Load payload
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      res_q <= data_i;
    end
  end

  assign m_axis_tvalid = vld_q;
  assign m_axis_tdata  = {2'b00, res_q.delivered, res_q.seq, res_q.channel, res_q.status};
  assign m_axis_tuser  = res_q.retransmit;
  assign m_axis_tlast  = res_q.last;

endmodule

>>> rtl/ack_retransmit_tracker_unit.sv
// Sender-side ack tracker: sequence counters, pending table walks, retransmit on tick.
// Send, unused action, empty-table ack or query: the result is loaded from S_OUT (a tick that
// retransmits nothing passes S_TICK first); input is taken again once the result is loaded.
// Ack and query: S_SRD, S_SCHK per entry searched, plus S_SHCHK, S_SHWR per entry shifted on removal.
// Retransmitting tick: one table pass per channel, a read request and a data check for each entry.
// Reset clears counters, accumulator, fill count, control and config registers; not payloads or table.
module ack_retransmit_tracker_unit #(
  parameter int unsigned CHANNELS      = 8,
  parameter int unsigned PENDING_DEPTH = 32
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  // Configuration write port
  input  logic                               cfg_we_i,
  input  logic [art_pkg::CFG_ADDR_W-1:0]     cfg_addr_i,
  input  logic [art_pkg::CFG_W-1:0]          cfg_wdata_i,
  // Input stream
  input  logic                               s_axis_tvalid,
  output logic                               s_axis_tready,
  // channel[2:0], seq[34:3], elapsed[50:35], zero pad
  input  logic [art_pkg::IN_DATA_W-1:0]      s_axis_tdata,
  // action[2:0]
  input  logic [art_pkg::ACT_W-1:0]          s_axis_tuser,
  // Result stream
  output logic                               m_axis_tvalid,
  input  logic                               m_axis_tready,
  // status[1:0], out_channel[4:2], out_seq[36:5], delivered[37], zero pad
  output logic [art_pkg::OUT_DATA_W-1:0]     m_axis_tdata,
  // retransmit[0]
  output logic                               m_axis_tuser,
  output logic                               m_axis_tlast
);

  localparam int unsigned IDX_W  = $clog2(PENDING_DEPTH);
  localparam int unsigned CNT_W  = $clog2(PENDING_DEPTH + 1);
  localparam int unsigned CIDX_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam int unsigned ENT_W  = $bits(art_pkg::entry_t);

  typedef enum logic [3:0] {
    S_IDLE,
    S_OUT,
    S_TICK,
    S_SRD,
    S_SCHK,
    S_SHCHK,
    S_SHWR,
    S_RTRD,
    S_RTCHK
  } state_e;

  // Reduce a channel number modulo CHANNELS
  function automatic logic [art_pkg::CH_W-1:0] reduce_ch(input logic [art_pkg::CH_W-1:0] ch);
    logic [art_pkg::CH_W:0] t;
    t = {1'b0, ch};
    for (int k = 0; k < 8; k++) begin
      if (t >= (art_pkg::CH_W + 1)'(CHANNELS)) begin
        t = t - (art_pkg::CH_W + 1)'(CHANNELS);
      end
    end
    return t[art_pkg::CH_W-1:0];
  endfunction

  // Input fields
  logic [art_pkg::ACT_W-1:0] in_act;
  logic [art_pkg::CH_W-1:0]  in_ch;
  logic [art_pkg::SEQ_W-1:0] in_seq;
  logic [art_pkg::EL_W-1:0]  in_el;
  logic [CIDX_W-1:0]         in_cidx;

  assign in_act  = s_axis_tuser;
  assign in_ch   = reduce_ch(s_axis_tdata[2:0]);
  assign in_seq  = s_axis_tdata[34:3];
  assign in_el   = s_axis_tdata[50:35];
  assign in_cidx = in_ch[CIDX_W-1:0];

  // Configuration registers
  logic                     blk_q;
  logic [art_pkg::CFG_W-1:0] ival_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      blk_q  <= 1'b0;
      ival_q <= art_pkg::RETX_INTERVAL_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_addr_i)
        art_pkg::REG_SEND_BLOCKED:  blk_q  <= cfg_wdata_i[0];
        art_pkg::REG_RETX_INTERVAL: ival_q <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  // Per-channel sequence counters
  logic [art_pkg::SEQ_W-1:0] rel_q   [CHANNELS];
  logic [art_pkg::SEQ_W-1:0] unrel_q [CHANNELS];
  logic                      rel_inc;
  logic                      unrel_inc;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int c = 0; c < CHANNELS; c++) begin
        rel_q[c]   <= '0;
        unrel_q[c] <= '0;
      end
    end else begin
      if (rel_inc) begin
        rel_q[in_cidx] <= rel_q[in_cidx] + 1'b1;
      end
      if (unrel_inc) begin
        unrel_q[in_cidx] <= unrel_q[in_cidx] + 1'b1;
      end
    end
  end

  // Pending table memory
  logic                mem_we;
  logic [IDX_W-1:0]    mem_waddr;
  art_pkg::entry_t     mem_wdata;
  logic [ENT_W-1:0]    mem_rdata;
  art_pkg::entry_t     rd;

  logic [CNT_W-1:0]    idx_q, idx_d;

  art_pend_mem #(
    .ADDR_W (IDX_W),
    .DATA_W (ENT_W)
  ) u_mem (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .raddr_i (idx_q[IDX_W-1:0]),
    .rdata_o (mem_rdata)
  );

  assign rd = art_pkg::entry_t'(mem_rdata);

  // Output register
  logic             push;
  logic             can_load;
  art_pkg::result_t res_q, res_d;

  art_out_reg u_out (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .push_i        (push),
    .data_i        (res_q),
    .can_load_o    (can_load),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
  );

  // Control state
  state_e                    state_q, state_d;
  logic [art_pkg::ACT_W-1:0] act_q, act_d;
  logic [art_pkg::CH_W-1:0]  ch_q, ch_d;
  logic [art_pkg::SEQ_W-1:0] seq_q, seq_d;
  logic [art_pkg::CH_W-1:0]  rc_q, rc_d;
  logic                      hold_q, hold_d;
  logic [CNT_W-1:0]          fill_q, fill_d;
  logic [art_pkg::ACC_W-1:0] acc_q, acc_d;

  logic [art_pkg::ACC_W:0]   acc_sum;
  logic [art_pkg::ACC_W-1:0] ival_ext;
  logic [CNT_W-1:0]          idx_nxt;
  logic                      hit;
  logic                      rt_match;
  logic                      rt_step;
  logic                      last_idx;
  logic                      last_ch;

  assign s_axis_tready = (state_q == S_IDLE);
  assign acc_sum  = {1'b0, acc_q} + (art_pkg::ACC_W + 1)'(in_el);
  assign ival_ext = art_pkg::ACC_W'(ival_q);
  assign idx_nxt  = idx_q + 1'b1;
  assign hit      = (rd.channel == ch_q) && (rd.seq == seq_q);
  assign rt_match = (rd.channel == rc_q);
  assign rt_step  = !(rt_match && hold_q && !can_load);
  assign last_idx = (idx_nxt >= fill_q);
  assign last_ch  = (rc_q == art_pkg::CH_W'(CHANNELS - 1));

  // Sequence the table walks and build results
  always_comb begin
    state_d   = state_q;
    act_d     = act_q;
    ch_d      = ch_q;
    seq_d     = seq_q;
    res_d     = res_q;
    idx_d     = idx_q;
    rc_d      = rc_q;
    hold_d    = hold_q;
    fill_d    = fill_q;
    acc_d     = acc_q;
    push      = 1'b0;
    mem_we    = 1'b0;
    mem_waddr = fill_q[IDX_W-1:0];
    mem_wdata = '{channel: in_ch, seq: rel_q[in_cidx]};
    rel_inc   = 1'b0;
    unrel_inc = 1'b0;

    unique case (state_q)
      S_IDLE: begin
        if (s_axis_tvalid) begin
          act_d         = in_act;
          ch_d          = in_ch;
          seq_d         = in_seq;
          res_d         = '0;
          res_d.channel = in_ch;
          res_d.last    = 1'b1;
          state_d       = S_OUT;
          unique case (in_act)
            art_pkg::ACT_REL_SEND, art_pkg::ACT_UNREL_SEND: begin
              if (blk_q) begin
                res_d.status = art_pkg::STAT_BLOCKED;
              end else if (in_act == art_pkg::ACT_UNREL_SEND) begin
                res_d.seq = unrel_q[in_cidx];
                unrel_inc = 1'b1;
              end else if (fill_q == CNT_W'(PENDING_DEPTH)) begin
                res_d.status = art_pkg::STAT_FULL;
              end else begin
                // Append at the end of the valid prefix
                mem_we    = 1'b1;
                res_d.seq = rel_q[in_cidx];
                rel_inc   = 1'b1;
                fill_d    = fill_q + 1'b1;
              end
            end
            art_pkg::ACT_ACK, art_pkg::ACT_QUERY: begin
              if (fill_q == '0) begin
                if (in_act == art_pkg::ACT_ACK) begin
                  res_d.status = art_pkg::STAT_NOMATCH;
                end else begin
                  res_d.delivered = 1'b1;
                end
              end else begin
                idx_d   = '0;
                state_d = S_SRD;
              end
            end
            art_pkg::ACT_TICK: begin
              // Saturating accumulate; compare in the next cycle
              acc_d         = acc_sum[art_pkg::ACC_W] ? '1 : acc_sum[art_pkg::ACC_W-1:0];
              res_d.channel = '0;
              state_d       = S_TICK;
            end
            default: begin
              res_d.channel = '0;
            end
          endcase
        end
      end

      S_OUT: begin
        if (can_load) begin
          push    = 1'b1;
          state_d = S_IDLE;
        end
      end

      S_TICK: begin
        if (acc_q >= ival_ext) begin
          acc_d = acc_q - ival_ext;
          if (fill_q != '0) begin
            idx_d   = '0;
            rc_d    = '0;
            hold_d  = 1'b0;
            state_d = S_RTRD;
          end else begin
            state_d = S_OUT;
          end
        end else begin
          state_d = S_OUT;
        end
      end

      S_SRD: begin
        state_d = S_SCHK;
      end

      S_SCHK: begin
        if (hit) begin
          if (act_q == art_pkg::ACT_ACK) begin
            // Close the gap left by the removed entry
            idx_d   = idx_nxt;
            state_d = S_SHCHK;
          end else begin
            state_d = S_OUT;
          end
        end else if (last_idx) begin
          if (act_q == art_pkg::ACT_ACK) begin
            res_d.status = art_pkg::STAT_NOMATCH;
          end else begin
            res_d.delivered = 1'b1;
          end
          state_d = S_OUT;
        end else begin
          idx_d   = idx_nxt;
          state_d = S_SRD;
        end
      end

      S_SHCHK: begin
        if (idx_q < fill_q) begin
          state_d = S_SHWR;
        end else begin
          fill_d  = fill_q - 1'b1;
          state_d = S_OUT;
        end
      end

      S_SHWR: begin
        mem_we    = 1'b1;
        mem_waddr = IDX_W'(idx_q - 1'b1);
        mem_wdata = rd;
        idx_d     = idx_nxt;
        state_d   = S_SHCHK;
      end

      S_RTRD: begin
        state_d = S_RTCHK;
      end

      S_RTCHK: begin
        // Hold one result back so the final one can carry last
        if (rt_match && rt_step) begin
          push   = hold_q;
          res_d  = '{status: art_pkg::STAT_DONE, channel: rc_q, seq: rd.seq,
                     delivered: 1'b0, retransmit: 1'b1, last: 1'b0};
          hold_d = 1'b1;
        end
        if (rt_step) begin
          if (!last_idx) begin
            idx_d   = idx_nxt;
            state_d = S_RTRD;
          end else if (last_ch) begin
            res_d.last = 1'b1;
            state_d    = S_OUT;
          end else begin
            rc_d    = rc_q + 1'b1;
            idx_d   = '0;
            state_d = S_RTRD;
          end
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      idx_q   <= '0;
      rc_q    <= '0;
      hold_q  <= 1'b0;
      fill_q  <= '0;
      acc_q   <= '0;
    end else begin
      state_q <= state_d;
      idx_q   <= idx_d;
      rc_q    <= rc_d;
      hold_q  <= hold_d;
      fill_q  <= fill_d;
      acc_q   <= acc_d;
    end
  end

  // Item payload registers
  always_ff @(posedge clk_i) begin
    act_q <= act_d;
    ch_q  <= ch_d;
    seq_q <= seq_d;
    res_q <= res_d;
  end

`ifndef SYNTH
  // Fill count never passes the table depth
  a_fill_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fill_q <= CNT_W'(PENDING_DEPTH))
    else $error("pending fill count above table depth");

  // A completed ack removal frees exactly one entry
  a_ack_remove: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_SHCHK && idx_q >= fill_q) |=> fill_q == $past(fill_q - 1'b1))
    else $error("ack removal did not shrink the table by one");

  // An accepted reliable send with room takes one entry
  a_send_insert: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tvalid && s_axis_tready && s_axis_tuser == art_pkg::ACT_REL_SEND && !blk_q &&
     fill_q != CNT_W'(PENDING_DEPTH)) |=> fill_q == $past(fill_q + 1'b1))
    else $error("reliable send did not grow the table by one");

  // Retransmit results always report done status
  a_retx_status: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && m_axis_tuser) |-> m_axis_tdata[1:0] == art_pkg::STAT_DONE)
    else $error("retransmit result with non-done status");
`endif

endmodule
